// ===== rtl/core/pxcmd_pkg.sv =====
// ----------------------------------------------------------------------------
// pxcmd_pkg
// Shared types, constants and helpers of the pixel command formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package pxcmd_pkg;

    localparam int COORD_W      = 14;
    localparam int POS_W        = 15;
    localparam int RGB_W        = 24;
    localparam int NDIG         = 5;
    localparam int IDX_W        = 5;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;
    localparam int PIXEL_W      = 32;
    localparam int BYTE_W       = 8;
    localparam int MAX_DIMENSION_DEF = 9999;

    // q = (v * 52429) >> 19 equals v / 10 for every v below 262149
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam logic [7:0] CH_P  = 8'h50;
    localparam logic [7:0] CH_X  = 8'h58;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_A  = 8'h61;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH        = 3'd0,
        REG_HEIGHT       = 3'd1,
        REG_FILTER_EN    = 3'd2,
        REG_KEY_COLOR    = 3'd3,
        REG_X_OFFSET     = 3'd4,
        REG_Y_OFFSET     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic               filter_en;
        logic [RGB_W-1:0]   key_color;
        logic [COORD_W-1:0] x_offset;
        logic [COORD_W-1:0] y_offset;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic [RGB_W-1:0] rgb;
    } coord_t;

    typedef logic [NDIG-1:0][3:0] digits_t;

    typedef struct packed {
        digits_t          xd;
        digits_t          yd;
        logic [RGB_W-1:0] rgb;
    } line_t;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10)
            c = CH_0 + {4'd0, n};
        else
            c = CH_A + {4'd0, n} - 8'd10;
        return c;
    endfunction

    // number of significant decimal digits, at least one
    function automatic logic [2:0] digit_count(input digits_t d);
        logic [2:0] n;
        if (d[4] != 4'd0)
            n = 3'd5;
        else if (d[3] != 4'd0)
            n = 3'd4;
        else if (d[2] != 4'd0)
            n = 3'd3;
        else if (d[1] != 4'd0)
            n = 3'd2;
        else
            n = 3'd1;
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pxcmd_position.sv =====
// ----------------------------------------------------------------------------
// pxcmd_position
// Input register: raster position counters, skip decision, offset sums.
// ----------------------------------------------------------------------------
`default_nettype none

module pxcmd_position #(
    parameter int MAX_DIMENSION = pxcmd_pkg::MAX_DIMENSION_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire pxcmd_pkg::cfg_t                cfg,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // red [7:0], green [15:8], blue [23:16], alpha [31:24]
    input  wire logic [pxcmd_pkg::PIXEL_W-1:0]  s_tdata,
    output logic                                hold_valid,
    input  wire logic                           hold_ready,
    output pxcmd_pkg::coord_t                   hold_data
);
    import pxcmd_pkg::*;

    localparam logic [COORD_W-1:0] MAX_DIM = COORD_W'(MAX_DIMENSION);

    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic               hold_valid_reg, hold_valid_next;
    coord_t             hold_data_reg;

    logic [7:0]         red, green, blue, alpha;
    logic [RGB_W-1:0]   rgb;
    logic [COORD_W-1:0] col_inc, row_inc;
    logic               col_wrap, row_wrap;
    logic               oversized, skip, accept;

    assign red   = s_tdata[7:0];
    assign green = s_tdata[15:8];
    assign blue  = s_tdata[23:16];
    assign alpha = s_tdata[31:24];
    assign rgb   = {red, green, blue};

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !hold_valid_reg || hold_ready;

    assign oversized = (cfg.width > MAX_DIM) || (cfg.height > MAX_DIM);
    assign skip      = oversized || (alpha == 8'd0)
                       || (cfg.filter_en && (rgb == cfg.key_color));

    assign col_inc  = col_reg + COORD_W'(1);
    assign row_inc  = row_reg + COORD_W'(1);
    // a count beyond a lowered size wraps on the next pixel
    assign col_wrap = (col_inc >= cfg.width) || (col_reg >= cfg.width);
    assign row_wrap = (row_inc >= cfg.height) || (row_reg >= cfg.height);

    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_inc;
            end
            else
            begin
                col_next = col_inc;
            end
            hold_valid_next = !skip;
        end
        else if (hold_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_data_reg.px  <= {1'b0, col_reg} + {1'b0, cfg.x_offset};
            hold_data_reg.py  <= {1'b0, row_reg} + {1'b0, cfg.y_offset};
            hold_data_reg.rgb <= rgb;
        end
    end

    assign hold_valid = hold_valid_reg;
    assign hold_data  = hold_data_reg;

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(col_reg) && $stable(row_reg))
        else $error("position moved without a request");

    a_row_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !col_wrap |=> $stable(row_reg))
        else $error("row advanced without column wrap");

    a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg && !hold_ready |=> hold_valid_reg && $stable(hold_data_reg))
        else $error("pending coordinate lost");

endmodule

`default_nettype wire

// ===== rtl/core/pxcmd_bcd.sv =====
// ----------------------------------------------------------------------------
// pxcmd_bcd
// Binary to decimal conversion of both coordinates, one digit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pxcmd_bcd (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pxcmd_pkg::coord_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output pxcmd_pkg::line_t        out_data
);
    import pxcmd_pkg::*;

    localparam int PROD_W = POS_W + 16;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [2:0]       step_reg, step_next;
    logic [POS_W-1:0] xv_reg, yv_reg;
    digits_t          xd_reg, yd_reg;
    logic [RGB_W-1:0] rgb_reg;

    logic [PROD_W-1:0] xprod, yprod;
    logic [POS_W-1:0]  xq, yq;
    logic [POS_W-1:0]  xr, yr;
    logic              accept, last_step;

    assign in_ready  = !busy_reg && (!done_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign last_step = (step_reg == 3'(NDIG - 1));

    assign xprod = {16'd0, xv_reg} * {{POS_W{1'b0}}, DIV10_MUL};
    assign yprod = {16'd0, yv_reg} * {{POS_W{1'b0}}, DIV10_MUL};
    assign xq    = POS_W'(xprod >> DIV10_SHIFT);
    assign yq    = POS_W'(yprod >> DIV10_SHIFT);
    assign xr    = xv_reg - ((xq << 3) + (xq << 1));
    assign yr    = yv_reg - ((yq << 3) + (yq << 1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 3'd1;
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (out_ready)
        begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // digits shift in from the top; units end at index 0
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            xv_reg  <= in_data.px;
            yv_reg  <= in_data.py;
            rgb_reg <= in_data.rgb;
        end
        else if (busy_reg)
        begin
            xv_reg <= xq;
            yv_reg <= yq;
            xd_reg <= {xr[3:0], xd_reg[NDIG-1:1]};
            yd_reg <= {yr[3:0], yd_reg[NDIG-1:1]};
        end
    end

    assign out_valid    = done_reg;
    assign out_data.xd  = xd_reg;
    assign out_data.yd  = yd_reg;
    assign out_data.rgb = rgb_reg;

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !done_reg)
        else $error("conversion flagged done while running");

    a_step_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && last_step |=> done_reg && !busy_reg)
        else $error("conversion did not finish after last digit");

endmodule

`default_nettype wire

// ===== rtl/core/pxcmd_emit.sv =====
// ----------------------------------------------------------------------------
// pxcmd_emit
// Line sequencer: walks one command line and drives the byte output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pxcmd_emit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pxcmd_pkg::line_t   in_data,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // text_byte [7:0]
    output logic [pxcmd_pkg::BYTE_W-1:0] m_tdata,
    output logic                    m_tlast
);
    import pxcmd_pkg::*;

    logic             line_valid_reg, line_valid_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;

    digits_t          xd_reg, yd_reg;
    logic [RGB_W-1:0] rgb_reg;
    logic [IDX_W-1:0] xe_reg, ye_reg, hs_reg, nl_reg;

    logic [IDX_W-1:0] xe_in, ye_in, hs_in;
    logic [IDX_W-1:0] kx, ky, kh;
    logic [7:0]       byte_sel;
    logic             adv, at_end, load;

    function automatic logic [3:0] digit_pick(input digits_t d, input logic [2:0] k);
        logic [3:0] v;
        case (k)
            3'd0:    v = d[0];
            3'd1:    v = d[1];
            3'd2:    v = d[2];
            3'd3:    v = d[3];
            3'd4:    v = d[4];
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] nibble_pick(input logic [RGB_W-1:0] c,
                                               input logic [2:0] j);
        logic [3:0] v;
        case (j)
            3'd0:    v = c[23:20];
            3'd1:    v = c[19:16];
            3'd2:    v = c[15:12];
            3'd3:    v = c[11:8];
            3'd4:    v = c[7:4];
            3'd5:    v = c[3:0];
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    // layout: "PX " x-digits ' ' y-digits ' ' six hex digits '\n'
    assign xe_in = IDX_W'(3) + IDX_W'(digit_count(in_data.xd));
    assign ye_in = xe_in + IDX_W'(1) + IDX_W'(digit_count(in_data.yd));
    assign hs_in = ye_in + IDX_W'(1);

    assign at_end   = (idx_reg == nl_reg);
    assign adv      = line_valid_reg && (!out_valid_reg || m_tready);
    assign in_ready = !line_valid_reg || (adv && at_end);
    assign load     = in_valid && in_ready;

    // digits are printed most significant first
    assign kx = xe_reg - IDX_W'(1) - idx_reg;
    assign ky = ye_reg - IDX_W'(1) - idx_reg;
    assign kh = idx_reg - hs_reg;

    always_comb
    begin
        if (idx_reg == IDX_W'(0))
            byte_sel = CH_P;
        else if (idx_reg == IDX_W'(1))
            byte_sel = CH_X;
        else if (idx_reg == IDX_W'(2))
            byte_sel = CH_SP;
        else if (idx_reg < xe_reg)
            byte_sel = CH_0 + {4'd0, digit_pick(xd_reg, kx[2:0])};
        else if (idx_reg == xe_reg)
            byte_sel = CH_SP;
        else if (idx_reg < ye_reg)
            byte_sel = CH_0 + {4'd0, digit_pick(yd_reg, ky[2:0])};
        else if (idx_reg == ye_reg)
            byte_sel = CH_SP;
        else if (idx_reg < nl_reg)
            byte_sel = hex_char(nibble_pick(rgb_reg, kh[2:0]));
        else
            byte_sel = CH_NL;
    end

    always_comb
    begin
        line_valid_next = line_valid_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg;
        if (adv)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        if (load)
        begin
            line_valid_next = 1'b1;
            idx_next        = '0;
        end
        else if (adv)
        begin
            if (at_end)
                line_valid_next = 1'b0;
            else
                idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_valid_reg <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            line_valid_reg <= line_valid_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            xd_reg  <= in_data.xd;
            yd_reg  <= in_data.yd;
            rgb_reg <= in_data.rgb;
            xe_reg  <= xe_in;
            ye_reg  <= ye_in;
            hs_reg  <= hs_in;
            nl_reg  <= hs_in + IDX_W'(6);
        end
        if (adv)
        begin
            out_byte_reg <= byte_sel;
            out_last_reg <= at_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    a_last_newline: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata == CH_NL)
        else $error("line end flag on a byte other than newline");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_valid_reg |-> idx_reg <= nl_reg)
        else $error("byte index ran past the line");

endmodule

`default_nettype wire

// ===== rtl/core/pixel_filter_command_formatter.sv =====
// ----------------------------------------------------------------------------
// pixel_filter_command_formatter
// Turns a raster stream of RGBA pixels into "PX x y rrggbb\n" text commands.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_t* request channel in raster order. Column and row
//   counters wrap at the configured width and height. A pixel with zero alpha,
//   or whose RGB matches the filter color while filtering is on, is dropped,
//   as is every pixel while width or height exceeds MAX_DIMENSION; otherwise
//   one ASCII line (14 to 22 bytes) leaves on m_t*, one byte per request,
//   with m_tlast on the closing newline.
//   Registers are written over cfg_valid/cfg_index/cfg_data (always ready);
//   the user must write them only while the block is idle (not enforced).
//   Throughput: dropped pixels are taken every cycle unless a kept pixel
//   waits in the hold register. An emitted line holds the output, one byte
//   per cycle from the output register while m_tready is high. Decimal
//   conversion (one digit per cycle) and one pending pixel overlap the line
//   in flight. On an empty pipeline a pixel passes the hold register,
//   conversion and line sequencer before its first byte is registered.
//   Reset clears position counters and all buffers; registers return to
//   width 1, height 1, everything else 0. When m_tready is low, bytes hold
//   and the input backs up once the pending and conversion stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_filter_command_formatter #(
    parameter int MAX_DIMENSION = pxcmd_pkg::MAX_DIMENSION_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pxcmd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pxcmd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // red [7:0], green [15:8], blue [23:16], alpha [31:24]
    input  wire logic [pxcmd_pkg::PIXEL_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // text_byte [7:0]
    output logic [pxcmd_pkg::BYTE_W-1:0]           m_tdata,
    output logic                                   m_tlast
);
    import pxcmd_pkg::*;

    cfg_t   cfg_reg;
    logic   hold_valid, hold_ready;
    coord_t hold_data;
    logic   conv_valid, conv_ready;
    line_t  conv_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width        <= COORD_W'(1);
            cfg_reg.height       <= COORD_W'(1);
            cfg_reg.filter_en    <= 1'b0;
            cfg_reg.key_color    <= '0;
            cfg_reg.x_offset     <= '0;
            cfg_reg.y_offset     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WIDTH:        cfg_reg.width        <= cfg_data[COORD_W-1:0];
                REG_HEIGHT:       cfg_reg.height       <= cfg_data[COORD_W-1:0];
                REG_FILTER_EN:    cfg_reg.filter_en    <= cfg_data[0];
                REG_KEY_COLOR:    cfg_reg.key_color    <= cfg_data[RGB_W-1:0];
                REG_X_OFFSET:     cfg_reg.x_offset     <= cfg_data[COORD_W-1:0];
                REG_Y_OFFSET:     cfg_reg.y_offset     <= cfg_data[COORD_W-1:0];
                default:          ;
            endcase
        end
    end

    pxcmd_position #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_position (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .hold_valid (hold_valid),
        .hold_ready (hold_ready),
        .hold_data  (hold_data)
    );

    pxcmd_bcd u_bcd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hold_valid),
        .in_ready  (hold_ready),
        .in_data   (hold_data),
        .out_valid (conv_valid),
        .out_ready (conv_ready),
        .out_data  (conv_data)
    );

    pxcmd_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (conv_valid),
        .in_ready (conv_ready),
        .in_data  (conv_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the pixel command formatter against a behavioral model of its text
// output. Pixels go in over the input stream with random gaps; every output
// byte is compared with the expected "PX x y rrggbb\n" line, and the output
// side stalls at random, once for a long stretch.
// ----------------------------------------------------------------------------

module tb;

    import pxcmd_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    // expected text, oldest byte first
    text_char_t  pending_text[$];

    cfg_t        model_cfg;
    logic [13:0] column_pos;
    logic [13:0] row_pos;

    int          error_count = 0;
    int          cycle_count = 0;
    bit          sender_idle = 1'b1;
    bit          receiver_idle = 1'b1;
    int          long_hold_req = 0;
    int          hold_left = 0;
    int          stall_left = 0;

    pixel_filter_command_formatter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // behavioral model
    // ------------------------------------------------------------------
    function automatic void push_char(input logic [7:0] code, input logic last = 1'b0);
        text_char_t c;
        c.code = code;
        c.last = last;
        pending_text.push_back(c);
    endfunction

    function automatic void push_decimal(input int unsigned value);
        logic [7:0] digit_chars [5];
        int n;
        n = 0;
        do
        begin
            digit_chars[n] = 8'h30 + 8'(value % 10);
            value = value / 10;
            n++;
        end
        while (value != 0 && n < 5);
        while (n > 0)
        begin
            n--;
            push_char(digit_chars[n]);
        end
    endfunction

    function automatic void push_hex(input logic [7:0] value);
        string hex_set;
        hex_set = "0123456789abcdef";
        push_char(hex_set[value[7:4]]);
        push_char(hex_set[value[3:0]]);
    endfunction

    function automatic void advance_position();
        logic [13:0] next_col;
        logic [13:0] next_row;
        next_col = column_pos + 14'd1;
        if (next_col >= model_cfg.width || column_pos >= model_cfg.width)
        begin
            column_pos = '0;
            next_row = row_pos + 14'd1;
            if (next_row >= model_cfg.height || row_pos >= model_cfg.height)
                row_pos = '0;
            else
                row_pos = next_row;
        end
        else
            column_pos = next_col;
    endfunction

    function automatic void format_command(input pixel_t pix);
        int unsigned px;
        int unsigned py;
        bit          oversized;
        bit          skip;
        px = int'(column_pos) + int'(model_cfg.x_offset);
        py = int'(row_pos) + int'(model_cfg.y_offset);
        oversized = model_cfg.width > MAX_DIMENSION_DEF || model_cfg.height > MAX_DIMENSION_DEF;
        skip = oversized || pix.alpha == 8'd0 ||
               (model_cfg.filter_en && {pix.red, pix.green, pix.blue} == model_cfg.key_color);
        advance_position();
        if (!skip)
        begin
            push_char("P");
            push_char("X");
            push_char(" ");
            push_decimal(px);
            push_char(" ");
            push_decimal(py);
            push_char(" ");
            push_hex(pix.red);
            push_hex(pix.green);
            push_hex(pix.blue);
            push_char(8'h0A, 1'b1);
        end
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_pixel(input pixel_t pix);
        int gap;
        gap = (sender_idle && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do
            @(posedge clk);
        while (!s_tready);
        format_command(pix);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [23:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_WIDTH:        model_cfg.width        = value[13:0];
            REG_HEIGHT:       model_cfg.height       = value[13:0];
            REG_FILTER_EN:    model_cfg.filter_en    = value[0];
            REG_KEY_COLOR:    model_cfg.key_color    = value;
            REG_X_OFFSET:     model_cfg.x_offset     = value[13:0];
            REG_Y_OFFSET:     model_cfg.y_offset     = value[13:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_geometry(input logic [13:0] w, input logic [13:0] h,
                                  input logic [13:0] xo, input logic [13:0] yo);
        write_reg(REG_WIDTH, 24'(w));
        write_reg(REG_HEIGHT, 24'(h));
        write_reg(REG_X_OFFSET, 24'(xo));
        write_reg(REG_Y_OFFSET, 24'(yo));
    endtask

    // receiver: random stall bursts, plus one long hold on request
    always @(negedge clk)
    begin
        if (long_hold_req != 0)
        begin
            hold_left = long_hold_req;
            long_hold_req = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (receiver_idle && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_text.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h", m_tdata));
            else
            begin
                want = pending_text.pop_front();
                if (m_tdata !== want.code)
                    report_mismatch($sformatf("text byte %02h, want %02h", m_tdata, want.code));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("line end %b, want %b", m_tlast, want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    function automatic pixel_t make_pixel(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b, input logic [7:0] a);
        pixel_t p;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        p.alpha = a;
        return p;
    endfunction

    task automatic test_default_frame();
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'hff));
        send_pixel(make_pixel(8'hff, 8'hff, 8'hff, 8'h01));
        send_pixel(make_pixel(8'h12, 8'h34, 8'h56, 8'h00));
        send_pixel(make_pixel(8'h9a, 8'hbc, 8'hde, 8'h80));
        wait_idle();
    endtask

    task automatic test_color_filter();
        write_geometry(14'd3, 14'd2, 14'd10, 14'd99);
        write_reg(REG_KEY_COLOR, 24'h5ac30f);
        write_reg(REG_FILTER_EN, 24'd1);
        send_pixel(make_pixel(8'h5a, 8'hc3, 8'h0f, 8'hff));
        // match with a different alpha is still dropped
        send_pixel(make_pixel(8'h5a, 8'hc3, 8'h0f, 8'h01));
        send_pixel(make_pixel(8'h5b, 8'hc3, 8'h0f, 8'hff));
        send_pixel(make_pixel(8'h5a, 8'hc3, 8'h8f, 8'h7f));
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00));
        wait_idle();
        write_reg(REG_FILTER_EN, 24'd0);
        send_pixel(make_pixel(8'h5a, 8'hc3, 8'h0f, 8'h40));
        wait_idle();
    endtask

    task automatic test_zero_size();
        // upper data bits fall outside the 14-bit field, leaving width 0
        write_reg(REG_WIDTH, 24'hffc000);
        write_reg(REG_HEIGHT, 24'd0);
        write_reg(REG_X_OFFSET, 24'd3);
        write_reg(REG_Y_OFFSET, 24'd7);
        repeat (3) send_pixel(pixel_t'($urandom) | 32'h8000_0000);
        wait_idle();
    endtask

    task automatic test_oversized();
        write_geometry(14'd10000, 14'd2, 14'd0, 14'd0);
        repeat (3) send_pixel(make_pixel(8'h11, 8'h22, 8'h33, 8'hff));
        wait_idle();
        write_geometry(14'd2, 14'd16383, 14'd0, 14'd0);
        repeat (2) send_pixel(make_pixel(8'h44, 8'h55, 8'h66, 8'hff));
        wait_idle();
        write_reg(REG_HEIGHT, 24'd2);
        send_pixel(make_pixel(8'h77, 8'h88, 8'h99, 8'hff));
        wait_idle();
    endtask

    task automatic test_shrunk_counters();
        // walk the column count well past a small width while every pixel is dropped
        write_geometry(14'd16383, 14'd3, 14'd16383, 14'd16383);
        sender_idle = 1'b0;
        repeat (40) send_pixel(make_pixel(8'h01, 8'h02, 8'h03, 8'h00));
        sender_idle = 1'b1;
        wait_idle();
        write_reg(REG_WIDTH, 24'd4);
        send_pixel(make_pixel(8'hfe, 8'hdc, 8'hba, 8'hff));
        send_pixel(make_pixel(8'h01, 8'h23, 8'h45, 8'hff));
        wait_idle();
        // same for the row count
        write_geometry(14'd1, 14'd9999, 14'd0, 14'd9999);
        repeat (12) send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00));
        wait_idle();
        write_reg(REG_HEIGHT, 24'd5);
        send_pixel(make_pixel(8'hc0, 8'hff, 8'hee, 8'h02));
        send_pixel(make_pixel(8'h0c, 8'h0f, 8'h0e, 8'h03));
        wait_idle();
    endtask

    task automatic test_backpressure();
        write_geometry(14'd3, 14'd2, 14'd5, 14'd6);
        long_hold_req = 300;
        repeat (10) send_pixel(pixel_t'($urandom) | 32'h0100_0000);
        wait_idle();
    endtask

    function automatic logic [13:0] random_dimension();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 14'($urandom_range(1, 8));
        else if (pick < 80)
            return 14'($urandom_range(9, 64));
        else if (pick < 90)
            return 14'($urandom_range(9990, 9999));
        else if (pick < 96)
            return 14'd0;
        else
            return 14'($urandom_range(10000, 16383));
    endfunction

    function automatic logic [13:0] random_offset();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 14'($urandom_range(0, 20));
        else if (pick < 75)
            return 14'($urandom_range(9990, 9999));
        else if (pick < 90)
            return 14'($urandom);
        else
            return 14'd16383;
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        p = $urandom;
        if ($urandom_range(0, 7) == 0)
            p.alpha = 8'd0;
        if ($urandom_range(0, 4) == 0)
            {p.red, p.green, p.blue} = model_cfg.key_color;
        return p;
    endfunction

    task automatic test_random_frames(input int phases, input int per_phase);
        for (int ph = 0; ph < phases; ph++)
        begin
            if (ph == 0)
                write_geometry(14'd1, 14'd9999, 14'd9999, 14'd0);
            else if (ph == 1)
                write_geometry(14'd9999, 14'd1, 14'd0, 14'd16383);
            else
                write_geometry(random_dimension(), random_dimension(),
                               random_offset(), random_offset());
            write_reg(REG_FILTER_EN, 24'($urandom_range(0, 1)));
            write_reg(REG_KEY_COLOR, (ph == 1) ? 24'hffffff : 24'($urandom));
            if (ph >= phases - 2)
            begin
                sender_idle   = 1'b0;
                receiver_idle = 1'b0;
            end
            repeat (per_phase) send_pixel(random_pixel());
            wait_idle();
        end
    endtask

    initial
    begin
        model_cfg = '0;
        model_cfg.width  = 14'd1;
        model_cfg.height = 14'd1;
        column_pos = '0;
        row_pos    = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        test_default_frame();
        test_color_filter();
        test_zero_size();
        test_oversized();
        test_shrunk_counters();
        test_backpressure();
        test_random_frames(8, 40);

        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
